### src/plt_pkg.sv
package plt_pkg;

	localparam int VAL_W  = 8;
	localparam int CNT_W  = 9;
	localparam int LEN_W  = 9;
	localparam int PATH_W = 10;

	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [PATH_W-1:0] path_t;

	typedef enum logic {
		REG_MODE = 1'b0,
		REG_LEN  = 1'b1
	} reg_idx_t;

	// counts of the two children of one tree node
	typedef struct packed {
		cnt_t hi;
		cnt_t lo;
	} pair_t;

	// word walking down the chain, one level per cycle
	typedef struct packed {
		logic  dec;
		path_t key;
		path_t path;
		cnt_t  run;
	} tok_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic  clr;
		logic  cmt;
		logic  dec;
		path_t leaf;
		len_t  len;
	} ctl_t;

endpackage

### src/plt_cell.sv
module plt_cell #(
	parameter int TREE_LEVELS = 8,
	parameter int LEVEL       = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  plt_pkg::ctl_t  ctl,
	input  logic           tok_in_vld,
	input  plt_pkg::tok_t  tok_in,
	output logic           tok_out_vld,
	output plt_pkg::tok_t  tok_out,
	output plt_pkg::cnt_t  pick_cnt
);
	import plt_pkg::*;

	localparam int SHIFT = TREE_LEVELS - LEVEL + 1;
	localparam int CW    = TREE_LEVELS + 1;
	localparam logic [CW-1:0] SPAN = CW'(1) << (TREE_LEVELS - LEVEL);

	tok_t  tok_q;
	pair_t rd_q;
	logic  vld_q;
	logic  pick;
	pair_t upd;
	pair_t clr_pair;
	logic [CW-1:0] len_c;
	logic [CW-1:0] base_c;
	logic [CW-1:0] rem_c;
	logic [CW-1:0] rem_hi;

	always_comb begin
		pick = tok_q.dec ? (tok_q.run >= rd_q.lo) : tok_q.key[TREE_LEVELS-LEVEL];
		tok_out.dec  = tok_q.dec;
		tok_out.key  = tok_q.key;
		tok_out.path = {tok_q.path[PATH_W-2:0], pick};
		if (!pick)
			tok_out.run = tok_q.run;
		else if (tok_q.dec)
			tok_out.run = tok_q.run - rd_q.lo;
		else
			tok_out.run = tok_q.run + rd_q.lo;
		pick_cnt = pick ? rd_q.hi : rd_q.lo;
	end

	// commit: the chosen child gains (encode) or loses (decode) one leaf
	always_comb begin
		upd = rd_q;
		if (pick)
			upd.hi = tok_q.dec ? rd_q.hi - cnt_t'(1) : rd_q.hi + cnt_t'(1);
		else
			upd.lo = tok_q.dec ? rd_q.lo - cnt_t'(1) : rd_q.lo + cnt_t'(1);
	end

	// reload value of the pair that holds leaf ctl.leaf
	always_comb begin
		len_c  = CW'(ctl.len);
		base_c = CW'((ctl.leaf >> SHIFT) << SHIFT);
		rem_c  = len_c - base_c;
		rem_hi = (rem_c > SPAN) ? rem_c - SPAN : '0;
		clr_pair.lo = ctl.dec ? CNT_W'((rem_c >= SPAN) ? SPAN : rem_c) : '0;
		clr_pair.hi = ctl.dec ? CNT_W'((rem_hi >= SPAN) ? SPAN : rem_hi) : '0;
	end

	generate
		if (LEVEL == 1) begin : g_root
			pair_t root_q;

			always_ff @(posedge clk) begin
				if (ctl.clr)
					root_q <= clr_pair;
				else if (ctl.cmt)
					root_q <= upd;
				if (tok_in_vld)
					rd_q <= root_q;
			end
		end else begin : g_mem
			localparam int AW = LEVEL - 1;

			pair_t mem [1<<AW];
			logic [AW-1:0] wr_a;
			logic [AW-1:0] rd_a;

			assign rd_a = tok_in.path[AW-1:0];
			assign wr_a = ctl.clr ? ctl.leaf[SHIFT +: AW] : tok_q.path[AW-1:0];

			always_ff @(posedge clk) begin
				if (ctl.clr)
					mem[wr_a] <= clr_pair;
				else if (ctl.cmt)
					mem[wr_a] <= upd;
				if (tok_in_vld)
					rd_q <= mem[rd_a];
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (tok_in_vld)
			tok_q <= tok_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else
			vld_q <= tok_in_vld;
	end

	assign tok_out_vld = vld_q;

endmodule

### src/permutation_lehmer_tree_coder_unit.sv
// channel   | handshake              | payload
// ----------+------------------------+----------------------------
// item      | item_valid, item_ready | value
// res       | res_valid, res_ready   | result, last, error
// cfg       | cfg_we                 | cfg_index, cfg_data
//
// A word passes the cell chain, one tree level per cell, and then commits the counts and loads
// the output register.
// After the last word of a permutation, after any cfg write and after reset, a reload pass
// sweeps the used leaves, one per cycle (as many as the effective length; the length register resets to 256);
// item_ready is low meanwhile.
// A stalled result sits in the output register; a finished word then waits in the chain.
module permutation_lehmer_tree_coder_unit #(
	parameter int MAX_LEN     = 256,
	parameter int TREE_LEVELS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  plt_pkg::len_t   cfg_data,
	input  logic            item_valid,
	output logic            item_ready,
	input  plt_pkg::val_t   value,
	output logic            res_valid,
	input  logic            res_ready,
	output plt_pkg::val_t   result,
	output logic            last,
	output logic            error
);
	import plt_pkg::*;

	localparam int LEAVES = 1 << TREE_LEVELS;
	localparam int CAP0   = (MAX_LEN < LEAVES) ? MAX_LEN : LEAVES;
	localparam int CAP    = (CAP0 < 256) ? CAP0 : 256;
	localparam len_t LEN_CAP = LEN_W'(CAP);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	state_t state_q;
	logic   mode_q;
	len_t   len_raw_q;
	len_t   pos_q;
	val_t   sweep_q;
	val_t   v_q;
	logic   derr_q;
	logic   res_valid_q;
	val_t   result_q;
	logic   last_q;
	logic   error_q;

	len_t   len_eff;
	logic   accept;
	logic   slot_free;
	logic   done;
	logic   finish;
	logic   enc_err;
	logic   item_err;
	logic   is_last;
	val_t   item_res;
	ctl_t   ctl;

	tok_t   tok_c [TREE_LEVELS+1];
	logic   tok_v [TREE_LEVELS+1];
	cnt_t   pick_c [TREE_LEVELS:1];

	always_comb begin
		if (len_raw_q == '0)
			len_eff = len_t'(1);
		else if (len_raw_q > LEN_CAP)
			len_eff = LEN_CAP;
		else
			len_eff = len_raw_q;
	end

	assign item_ready = (state_q == ST_IDLE) && !cfg_we;
	assign accept     = item_valid && item_ready;
	assign slot_free  = !res_valid_q || res_ready;
	assign done       = tok_v[TREE_LEVELS];
	assign finish     = ((state_q == ST_RUN && done) || state_q == ST_HOLD) && slot_free;
	assign is_last    = (pos_q == len_eff - len_t'(1));

	assign enc_err  = (LEN_W'(v_q) >= len_eff) || (pick_c[TREE_LEVELS] != '0);
	assign item_err = mode_q ? derr_q : enc_err;

	always_comb begin
		if (item_err)
			item_res = '0;
		else if (mode_q)
			item_res = VAL_W'(tok_c[TREE_LEVELS].path);
		else
			item_res = VAL_W'(CNT_W'(v_q) - tok_c[TREE_LEVELS].run);
	end

	always_comb begin
		ctl.clr  = (state_q == ST_CLEAR);
		ctl.cmt  = finish && !item_err;
		ctl.dec  = mode_q;
		ctl.leaf = PATH_W'(sweep_q);
		ctl.len  = len_eff;
	end

	always_comb begin
		tok_c[0].dec  = mode_q;
		tok_c[0].key  = PATH_W'(value);
		tok_c[0].path = '0;
		tok_c[0].run  = mode_q ? CNT_W'(value) : '0;
	end
	assign tok_v[0] = accept;

	generate
		for (genvar k = 1; k <= TREE_LEVELS; k++) begin : g_cell
			plt_cell #(
				.TREE_LEVELS (TREE_LEVELS),
				.LEVEL       (k)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.tok_in_vld  (tok_v[k-1]),
				.tok_in      (tok_c[k-1]),
				.tok_out_vld (tok_v[k]),
				.tok_out     (tok_c[k]),
				.pick_cnt    (pick_c[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= 1'b0;
			len_raw_q   <= LEN_W'(256);
			pos_q       <= '0;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			if (finish)
				res_valid_q <= 1'b1;

			if (cfg_we) begin
				if (cfg_index == REG_MODE)
					mode_q <= cfg_data[0];
				else if (cfg_index == REG_LEN)
					len_raw_q <= cfg_data;
				state_q <= ST_CLEAR;
				sweep_q <= '0;
				pos_q   <= '0;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						if (LEN_W'(sweep_q) == len_eff - len_t'(1))
							state_q <= ST_IDLE;
						else
							sweep_q <= sweep_q + val_t'(1);
					end
					ST_IDLE: begin
						if (accept)
							state_q <= ST_RUN;
					end
					ST_RUN, ST_HOLD: begin
						if (finish) begin
							if (is_last) begin
								state_q <= ST_CLEAR;
								sweep_q <= '0;
								pos_q   <= '0;
							end else begin
								state_q <= ST_IDLE;
								pos_q   <= pos_q + len_t'(1);
							end
						end else if (done) begin
							state_q <= ST_HOLD;
						end
					end
					default: state_q <= ST_CLEAR;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= value;
			derr_q <= LEN_W'(value) >= (len_eff - pos_q);
		end
		if (finish) begin
			result_q <= item_res;
			last_q   <= is_last;
			error_q  <= item_err;
		end
	end

	assign res_valid = res_valid_q;
	assign result    = result_q;
	assign last      = last_q;
	assign error     = error_q;

endmodule

### src/plt_checker.sv
module plt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       item_valid,
	input logic       item_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] result,
	input logic       last,
	input logic       error
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result) && $stable(last)
			&& $stable(error))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error |-> result == 8'd0)
		else $error("rejected word carries a nonzero result");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second word taken while one is in the chain");

	a_cfg_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !item_ready)
		else $error("no reload pass after a cfg write");

endmodule

bind permutation_lehmer_tree_coder_unit plt_checker u_plt_checker (.*);
